FILE: rtl/core/mbf_pkg.sv
// Shared constants, register codes and control structs for the median blend filter.
package mbf_pkg;

  localparam int WINDOW_MAX_DEF = 16;
  localparam int SAMPLE_W       = 32;
  localparam int LEN_REG_W      = 5;
  localparam int WEIGHT_W       = 17;
  localparam int FRAC_W         = 16;
  localparam int ACC_W          = 48;
  localparam int PROD_W         = 49;
  localparam int CFG_ADDR_W     = 3;
  localparam int CFG_DATA_W     = 32;

  localparam logic [LEN_REG_W-1:0] LEN_RESET    = LEN_REG_W'(5);
  localparam logic [WEIGHT_W-1:0]  WEIGHT_RESET = WEIGHT_W'(32768);
  localparam logic [WEIGHT_W-1:0]  ONE_Q16      = WEIGHT_W'(65536);
  localparam logic [SAMPLE_W-1:0]  SIGN_BIAS    = 32'h8000_0000;

  typedef enum logic {
    REG_WINDOW_LEN   = 1'b0,
    REG_BLEND_WEIGHT = 1'b1
  } mbf_reg_t;

  typedef struct packed {
    logic shift;
    logic scan;
  } mbf_win_ctl_t;

  typedef struct packed {
    logic med_load;
    logic mul;
    logic sel_sample;
    logic acc_load;
    logic acc_add;
  } mbf_mac_ctl_t;

endpackage

FILE: rtl/core/mbf_if.sv
// Valid/ready channel interfaces for samples and filtered results.
interface mbf_in_if;
  logic                                 valid;
  logic                                 ready;
  logic signed [mbf_pkg::SAMPLE_W-1:0]  sample;

  modport source (output valid, output sample, input ready);
  modport sink   (input valid, input sample, output ready);
endinterface

interface mbf_out_if;
  logic                                 valid;
  logic                                 ready;
  logic signed [mbf_pkg::SAMPLE_W-1:0]  filtered;
  logic                                 valid_res;

  modport source (output valid, output filtered, output valid_res, input ready);
  modport sink   (input valid, input filtered, input valid_res, output ready);
endinterface

FILE: rtl/core/median_blend_filter_unit.sv
// Top level of the sliding-window median filter with blend toward the sample.
//
// Usage:
//   in_chan carries one signed Q16.16 sample per beat; out_chan returns one
//   beat per sample: filtered (Q16.16) and valid_res. The window keeps the
//   newest WINDOW_MAX samples; the median spans the newest n of them, n being
//   window_len (register 0, byte 0x0) clamped to 1..WINDOW_MAX, blended by
//   blend_weight in Q1.16 (register 1, byte 0x4), capped at 1.0. Until the
//   window holds n samples, filtered is 0 and valid_res is 0.
// Timing:
//   in_chan.ready is high only while the sequencer is idle. With a full window
//   the result passes a rank scan over the n effective samples through the
//   shared compare bank, one drain, one median add, three multiply/accumulate
//   steps and one output load, which waits while out_chan still holds an
//   unaccepted result. Before the window fills, the sequencer skips straight
//   to the output load.
//   The output register parts the two sides: a new sample is taken while the
//   previous result waits, and a finished result holds until out_chan drains.
// Reset:
//   rst_n clears the fill count, the sequencer and the output valid, and sets
//   window_len to 5 and blend_weight to 32768. No clearing pass is needed.
module median_blend_filter_unit #(
  parameter int WINDOW_MAX = mbf_pkg::WINDOW_MAX_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  mbf_in_if.sink                            in_chan,
  mbf_out_if.source                         out_chan,
  input  logic                              cfg_psel,
  input  logic                              cfg_penable,
  input  logic                              cfg_pwrite,
  input  logic [mbf_pkg::CFG_ADDR_W-1:0]    cfg_paddr,
  input  logic [mbf_pkg::CFG_DATA_W-1:0]    cfg_pwdata,
  output logic [mbf_pkg::CFG_DATA_W-1:0]    cfg_prdata,
  output logic                              cfg_pready
);

  localparam int IDX_W = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;
  localparam int LEN_W = $clog2(WINDOW_MAX + 1);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DRAIN,
    ST_MED,
    ST_MUL0,
    ST_MUL1,
    ST_MUL2,
    ST_DONE
  } state_t;

  state_t                         state_r, state_nxt;
  logic [LEN_W-1:0]               fill_r, fill_nxt;
  logic [LEN_W-1:0]               n_r, n_nxt;
  logic [LEN_W-1:0]               k_lo_r, k_lo_nxt;
  logic [LEN_W-1:0]               k_hi_r, k_hi_nxt;
  logic [IDX_W-1:0]               idx_r, idx_nxt;
  logic                           full_r, full_nxt;
  logic                           out_valid_r, out_valid_nxt;
  logic [mbf_pkg::SAMPLE_W-1:0]   out_filtered_r, out_filtered_nxt;
  logic                           out_res_r, out_res_nxt;

  logic [mbf_pkg::LEN_REG_W-1:0]  window_len;
  logic [mbf_pkg::WEIGHT_W-1:0]   weight_sat;
  logic [LEN_W-1:0]               n_eff;
  logic [LEN_W-1:0]               fill_inc;
  logic                           in_acc;
  mbf_pkg::mbf_win_ctl_t          win_ctl;
  mbf_pkg::mbf_mac_ctl_t          mac_ctl;
  logic [mbf_pkg::SAMPLE_W-1:0]   newest_b;
  logic [mbf_pkg::SAMPLE_W-1:0]   lo_b;
  logic [mbf_pkg::SAMPLE_W-1:0]   hi_b;
  logic [mbf_pkg::SAMPLE_W-1:0]   blend;

  mbf_cfg u_cfg (
    .clk        (clk),
    .rst_n      (rst_n),
    .psel       (cfg_psel),
    .penable    (cfg_penable),
    .pwrite     (cfg_pwrite),
    .paddr      (cfg_paddr),
    .pwdata     (cfg_pwdata),
    .prdata     (cfg_prdata),
    .pready     (cfg_pready),
    .window_len (window_len),
    .weight_sat (weight_sat)
  );

  mbf_window #(
    .WINDOW_MAX (WINDOW_MAX)
  ) u_window (
    .clk      (clk),
    .rst_n    (rst_n),
    .ctl      (win_ctl),
    .sample_b ($unsigned(in_chan.sample) ^ mbf_pkg::SIGN_BIAS),
    .idx      (idx_r),
    .n_len    (n_r),
    .k_lo     (k_lo_r),
    .k_hi     (k_hi_r),
    .newest_b (newest_b),
    .lo_r     (lo_b),
    .hi_r     (hi_b)
  );

  mbf_mac u_mac (
    .clk      (clk),
    .ctl      (mac_ctl),
    .lo_b     (lo_b),
    .hi_b     (hi_b),
    .sample_b (newest_b),
    .weight   (weight_sat),
    .filtered (blend)
  );

  always_comb begin
    if (window_len == '0) begin
      n_eff = LEN_W'(1);
    end else if (32'(window_len) > 32'(WINDOW_MAX)) begin
      n_eff = LEN_W'(WINDOW_MAX);
    end else begin
      n_eff = LEN_W'(window_len);
    end
  end

  assign fill_inc = (fill_r == LEN_W'(WINDOW_MAX)) ? fill_r : LEN_W'(fill_r + 1'b1);
  assign in_chan.ready = (state_r == ST_IDLE);
  assign in_acc        = in_chan.valid && in_chan.ready;

  always_comb begin
    win_ctl       = '0;
    mac_ctl       = '0;
    win_ctl.shift = in_acc;
    win_ctl.scan  = (state_r == ST_SCAN);
    case (state_r)
      ST_MED:  mac_ctl.med_load = 1'b1;
      ST_MUL0: mac_ctl.mul = 1'b1;
      ST_MUL1: begin
        mac_ctl.mul        = 1'b1;
        mac_ctl.sel_sample = 1'b1;
        mac_ctl.acc_load   = 1'b1;
      end
      ST_MUL2: mac_ctl.acc_add = 1'b1;
      default: ;
    endcase
  end

  always_comb begin
    state_nxt        = state_r;
    fill_nxt         = fill_r;
    n_nxt            = n_r;
    k_lo_nxt         = k_lo_r;
    k_hi_nxt         = k_hi_r;
    idx_nxt          = idx_r;
    full_nxt         = full_r;
    out_valid_nxt    = out_valid_r;
    out_filtered_nxt = out_filtered_r;
    out_res_nxt      = out_res_r;
    if (out_valid_r && out_chan.ready) begin
      out_valid_nxt = 1'b0;
    end
    case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          fill_nxt = fill_inc;
          n_nxt    = n_eff;
          k_lo_nxt = LEN_W'((n_eff - 1'b1) >> 1);
          k_hi_nxt = LEN_W'(n_eff >> 1);
          idx_nxt  = '0;
          full_nxt = (fill_inc >= n_eff);
          state_nxt = (fill_inc >= n_eff) ? ST_SCAN : ST_DONE;
        end
      end
      ST_SCAN: begin
        idx_nxt = IDX_W'(idx_r + 1'b1);
        if (LEN_W'(idx_r) == LEN_W'(n_r - 1'b1)) begin
          state_nxt = ST_DRAIN;
        end
      end
      ST_DRAIN: state_nxt = ST_MED;
      ST_MED:   state_nxt = ST_MUL0;
      ST_MUL0:  state_nxt = ST_MUL1;
      ST_MUL1:  state_nxt = ST_MUL2;
      ST_MUL2:  state_nxt = ST_DONE;
      ST_DONE: begin
        if (!out_valid_r || out_chan.ready) begin
          out_valid_nxt    = 1'b1;
          out_filtered_nxt = full_r ? blend : '0;
          out_res_nxt      = full_r;
          state_nxt        = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      fill_r      <= '0;
      n_r         <= LEN_W'(1);
      k_lo_r      <= '0;
      k_hi_r      <= '0;
      idx_r       <= '0;
      full_r      <= 1'b0;
      out_valid_r <= 1'b0;
      out_res_r   <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      fill_r      <= fill_nxt;
      n_r         <= n_nxt;
      k_lo_r      <= k_lo_nxt;
      k_hi_r      <= k_hi_nxt;
      idx_r       <= idx_nxt;
      full_r      <= full_nxt;
      out_valid_r <= out_valid_nxt;
      out_res_r   <= out_res_nxt;
    end
    out_filtered_r <= out_filtered_nxt;
  end

  assign out_chan.valid     = out_valid_r;
  assign out_chan.filtered  = $signed(out_filtered_r);
  assign out_chan.valid_res = out_res_r;

  a_short_window_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_res_r |-> out_filtered_r == '0)
    else $error("result without a full window carries a nonzero value");

  a_accept_leaves_idle: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> state_r != ST_IDLE)
    else $error("sequencer stayed idle after taking a sample");

  a_scan_in_window: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_SCAN |-> LEN_W'(idx_r) < n_r)
    else $error("rank scan index ran past the window length");

  a_fill_bounded: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r <= LEN_W'(WINDOW_MAX))
    else $error("fill count exceeds window depth");

endmodule

FILE: rtl/core/mbf_cfg.sv
// APB-style register block for window length and blend weight.
module mbf_cfg (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [mbf_pkg::CFG_ADDR_W-1:0]      paddr,
  input  logic [mbf_pkg::CFG_DATA_W-1:0]      pwdata,
  output logic [mbf_pkg::CFG_DATA_W-1:0]      prdata,
  output logic                                pready,
  output logic [mbf_pkg::LEN_REG_W-1:0]       window_len,
  output logic [mbf_pkg::WEIGHT_W-1:0]        weight_sat
);

  logic [mbf_pkg::LEN_REG_W-1:0] len_r;
  logic [mbf_pkg::LEN_REG_W-1:0] len_nxt;
  logic [mbf_pkg::WEIGHT_W-1:0]  weight_r;
  logic [mbf_pkg::WEIGHT_W-1:0]  weight_nxt;
  mbf_pkg::mbf_reg_t             reg_sel;
  logic                          wr_en;

  assign pready  = 1'b1;
  assign reg_sel = mbf_pkg::mbf_reg_t'(paddr[2]);
  assign wr_en   = psel && penable && pwrite && pready;

  always_comb begin
    len_nxt    = len_r;
    weight_nxt = weight_r;
    if (wr_en) begin
      case (reg_sel)
        mbf_pkg::REG_WINDOW_LEN:   len_nxt    = pwdata[mbf_pkg::LEN_REG_W-1:0];
        mbf_pkg::REG_BLEND_WEIGHT: weight_nxt = pwdata[mbf_pkg::WEIGHT_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      len_r    <= mbf_pkg::LEN_RESET;
      weight_r <= mbf_pkg::WEIGHT_RESET;
    end else begin
      len_r    <= len_nxt;
      weight_r <= weight_nxt;
    end
  end

  always_comb begin
    case (reg_sel)
      mbf_pkg::REG_WINDOW_LEN:   prdata = mbf_pkg::CFG_DATA_W'(len_r);
      mbf_pkg::REG_BLEND_WEIGHT: prdata = mbf_pkg::CFG_DATA_W'(weight_r);
      default:                   prdata = '0;
    endcase
  end

  assign window_len = len_r;
  assign weight_sat = (weight_r > mbf_pkg::ONE_Q16) ? mbf_pkg::ONE_Q16 : weight_r;

endmodule

FILE: rtl/core/mbf_window.sv
// Sample shift line with a rank compare bank that picks the two middle values.
module mbf_window #(
  parameter int WINDOW_MAX = mbf_pkg::WINDOW_MAX_DEF,
  localparam int IDX_W = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1,
  localparam int LEN_W = $clog2(WINDOW_MAX + 1)
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  mbf_pkg::mbf_win_ctl_t          ctl,
  input  logic [mbf_pkg::SAMPLE_W-1:0]   sample_b,
  input  logic [IDX_W-1:0]               idx,
  input  logic [LEN_W-1:0]               n_len,
  input  logic [LEN_W-1:0]               k_lo,
  input  logic [LEN_W-1:0]               k_hi,
  output logic [mbf_pkg::SAMPLE_W-1:0]   newest_b,
  output logic [mbf_pkg::SAMPLE_W-1:0]   lo_r,
  output logic [mbf_pkg::SAMPLE_W-1:0]   hi_r
);

  logic [mbf_pkg::SAMPLE_W-1:0] taps_r [WINDOW_MAX];
  logic [mbf_pkg::SAMPLE_W-1:0] cand;
  logic [mbf_pkg::SAMPLE_W-1:0] cand_r;
  logic [WINDOW_MAX-1:0]        less_nxt;
  logic [WINDOW_MAX-1:0]        leq_nxt;
  logic [WINDOW_MAX-1:0]        less_r;
  logic [WINDOW_MAX-1:0]        leq_r;
  logic                         rank_vld_r;
  logic [LEN_W-1:0]             less_cnt;
  logic [LEN_W-1:0]             leq_cnt;
  logic                         hit_lo;
  logic                         hit_hi;

  assign cand     = taps_r[idx];
  assign newest_b = taps_r[0];

  always_comb begin
    for (int j = 0; j < WINDOW_MAX; j++) begin
      less_nxt[j] = (LEN_W'(j) < n_len) && (taps_r[j] <  cand);
      leq_nxt[j]  = (LEN_W'(j) < n_len) && (taps_r[j] <= cand);
    end
  end

  assign less_cnt = LEN_W'($countones(less_r));
  assign leq_cnt  = LEN_W'($countones(leq_r));
  assign hit_lo   = rank_vld_r && (less_cnt <= k_lo) && (k_lo < leq_cnt);
  assign hit_hi   = rank_vld_r && (less_cnt <= k_hi) && (k_hi < leq_cnt);

  always_ff @(posedge clk) begin
    if (ctl.shift) begin
      taps_r[0] <= sample_b;
      for (int i = 1; i < WINDOW_MAX; i++) begin
        taps_r[i] <= taps_r[i-1];
      end
    end
    less_r <= less_nxt;
    leq_r  <= leq_nxt;
    cand_r <= cand;
    if (hit_lo) begin
      lo_r <= cand_r;
    end
    if (hit_hi) begin
      hi_r <= cand_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rank_vld_r <= 1'b0;
    end else begin
      rank_vld_r <= ctl.scan;
    end
  end

endmodule

FILE: rtl/core/mbf_mac.sv
// Shared multiplier and accumulator that blends the median with the sample.
module mbf_mac (
  input  logic                           clk,
  input  mbf_pkg::mbf_mac_ctl_t          ctl,
  input  logic [mbf_pkg::SAMPLE_W-1:0]   lo_b,
  input  logic [mbf_pkg::SAMPLE_W-1:0]   hi_b,
  input  logic [mbf_pkg::SAMPLE_W-1:0]   sample_b,
  input  logic [mbf_pkg::WEIGHT_W-1:0]   weight,
  output logic [mbf_pkg::SAMPLE_W-1:0]   filtered
);

  logic [mbf_pkg::SAMPLE_W:0]    mid_sum;
  logic [mbf_pkg::SAMPLE_W-1:0]  med_r;
  logic [mbf_pkg::SAMPLE_W-1:0]  mul_a;
  logic [mbf_pkg::WEIGHT_W-1:0]  mul_b;
  logic [mbf_pkg::PROD_W-1:0]    prod_r;
  logic [mbf_pkg::ACC_W-1:0]     acc_r;

  assign mid_sum = (mbf_pkg::SAMPLE_W+1)'(lo_b) + (mbf_pkg::SAMPLE_W+1)'(hi_b);
  assign mul_a   = ctl.sel_sample ? sample_b : med_r;
  assign mul_b   = ctl.sel_sample ? mbf_pkg::WEIGHT_W'(mbf_pkg::ONE_Q16 - weight) : weight;

  always_ff @(posedge clk) begin
    if (ctl.med_load) begin
      med_r <= mid_sum[mbf_pkg::SAMPLE_W:1];
    end
    if (ctl.mul) begin
      prod_r <= mbf_pkg::PROD_W'(mul_a) * mbf_pkg::PROD_W'(mul_b);
    end
    if (ctl.acc_load) begin
      acc_r <= prod_r[mbf_pkg::ACC_W-1:0];
    end else if (ctl.acc_add) begin
      acc_r <= acc_r + prod_r[mbf_pkg::ACC_W-1:0];
    end
  end

  assign filtered = acc_r[mbf_pkg::FRAC_W +: mbf_pkg::SAMPLE_W] ^ mbf_pkg::SIGN_BIAS;

endmodule

FILE: tb/sv/tb_median_blend_filter_unit.sv
`timescale 1ns / 1ps
// Self-checking testbench for median_blend_filter_unit: directed table, then random phases.
module tb_median_blend_filter_unit;

  localparam int ITEMS_TOTAL   = 1150;
  localparam int DIR_N         = 32;
  localparam int HOLD_CYCLES   = 300;
  localparam int SETTLE_CYCLES = 40;
  localparam int PRINT_CAP     = 100;
  localparam logic [mbf_pkg::SAMPLE_W-1:0] POS_MAX = 32'h7FFF_FFFF;
  localparam logic [mbf_pkg::SAMPLE_W-1:0] NEG_MAX = 32'h8000_0000;

  typedef struct packed {
    logic [mbf_pkg::SAMPLE_W-1:0] filtered;
    logic                         valid_res;
  } res_beat_t;

  typedef struct packed {
    logic                           is_cfg;
    mbf_pkg::mbf_reg_t              reg_id;
    logic [mbf_pkg::CFG_DATA_W-1:0] data;
    logic                           typed;
    res_beat_t                      want;
  } dir_row_t;

  logic                           clk;
  logic                           rst_n;
  logic                           cfg_psel;
  logic                           cfg_penable;
  logic                           cfg_pwrite;
  logic [mbf_pkg::CFG_ADDR_W-1:0] cfg_paddr;
  logic [mbf_pkg::CFG_DATA_W-1:0] cfg_pwdata;
  logic [mbf_pkg::CFG_DATA_W-1:0] cfg_prdata;
  logic                           cfg_pready;

  mbf_in_if  smp_if ();
  mbf_out_if res_if ();

  logic [mbf_pkg::SAMPLE_W-1:0]  sample_hist [mbf_pkg::WINDOW_MAX_DEF];
  int                            stored_cnt = 0;
  logic [mbf_pkg::LEN_REG_W-1:0] med_len_cfg = mbf_pkg::LEN_RESET;
  logic [mbf_pkg::WEIGHT_W-1:0]  med_weight_cfg = mbf_pkg::WEIGHT_RESET;
  res_beat_t                     pending_res [$];
  int                            mismatch_cnt = 0;
  int                            sent_cnt = 0;
  bit                            idle_on = 1'b1;
  bit                            hold_req = 1'b0;
  dir_row_t                      dir_tab [DIR_N];

  median_blend_filter_unit i_dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_chan     (smp_if),
    .out_chan    (res_if),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #5_000_000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  task automatic flag_mismatch(input string what, input logic [mbf_pkg::SAMPLE_W-1:0] got,
                               input logic [mbf_pkg::SAMPLE_W-1:0] want);
    if (mismatch_cnt < PRINT_CAP)
      $display("%0t MISMATCH %s: got %h, want %h", $time, what, got, want);
    mismatch_cnt++;
  endtask

  // shift the sample in and return the blended median it yields
  function automatic res_beat_t blend_median(input logic [mbf_pkg::SAMPLE_W-1:0] s);
    logic [mbf_pkg::SAMPLE_W-1:0] ranked [mbf_pkg::WINDOW_MAX_DEF];
    logic [mbf_pkg::SAMPLE_W-1:0] key;
    logic [63:0]                  med_b;
    logic [63:0]                  wt;
    logic [63:0]                  acc;
    int                           n;
    int                           i;
    int                           j;
    res_beat_t                    r;
    if (med_len_cfg == 0) n = 1;
    else if (med_len_cfg > mbf_pkg::WINDOW_MAX_DEF) n = mbf_pkg::WINDOW_MAX_DEF;
    else n = int'(med_len_cfg);
    for (i = mbf_pkg::WINDOW_MAX_DEF - 1; i > 0; i--) sample_hist[i] = sample_hist[i-1];
    sample_hist[0] = s;
    if (stored_cnt < mbf_pkg::WINDOW_MAX_DEF) stored_cnt++;
    r = '0;
    if (stored_cnt >= n) begin
      for (i = 0; i < n; i++) begin
        key = sample_hist[i] ^ mbf_pkg::SIGN_BIAS;
        j = i;
        while (j > 0 && ranked[j-1] > key) begin
          ranked[j] = ranked[j-1];
          j--;
        end
        ranked[j] = key;
      end
      if (n % 2 == 0) med_b = (64'(ranked[n/2-1]) + 64'(ranked[n/2])) >> 1;
      else med_b = 64'(ranked[n/2]);
      wt = (med_weight_cfg > mbf_pkg::ONE_Q16) ? 64'(mbf_pkg::ONE_Q16)
                                               : 64'(med_weight_cfg);
      acc = med_b * wt + 64'(s ^ mbf_pkg::SIGN_BIAS) * (64'(mbf_pkg::ONE_Q16) - wt);
      r.filtered  = acc[47:16] - mbf_pkg::SIGN_BIAS;
      r.valid_res = 1'b1;
    end
    return r;
  endfunction

  function automatic dir_row_t cfg_row(input mbf_pkg::mbf_reg_t id,
                                       input logic [mbf_pkg::CFG_DATA_W-1:0] d);
    dir_row_t r;
    r = '0;
    r.is_cfg = 1'b1;
    r.reg_id = id;
    r.data   = d;
    return r;
  endfunction

  function automatic dir_row_t smp_row(input logic [mbf_pkg::SAMPLE_W-1:0] s);
    dir_row_t r;
    r = '0;
    r.data = s;
    return r;
  endfunction

  function automatic dir_row_t chk_row(input logic [mbf_pkg::SAMPLE_W-1:0] s,
                                       input logic [mbf_pkg::SAMPLE_W-1:0] f, input logic v);
    dir_row_t r;
    r = '0;
    r.data           = s;
    r.typed          = 1'b1;
    r.want.filtered  = f;
    r.want.valid_res = v;
    return r;
  endfunction

  function automatic logic [mbf_pkg::SAMPLE_W-1:0] next_sample(
      input logic [mbf_pkg::SAMPLE_W-1:0] base);
    case ($urandom_range(0, 7))
      0: return POS_MAX;
      1: return NEG_MAX;
      2: return base + 32'($urandom_range(0, 15));
      3: return base ^ 32'($urandom_range(0, 3));
      4: return 32'($urandom_range(0, 3)) - 32'd1;
      default: return $urandom;
    endcase
  endfunction

  task automatic cfg_write(input mbf_pkg::mbf_reg_t id,
                           input logic [mbf_pkg::CFG_DATA_W-1:0] d);
    logic [mbf_pkg::CFG_DATA_W-1:0] held;
    if (id == mbf_pkg::REG_WINDOW_LEN) held = mbf_pkg::CFG_DATA_W'(d[mbf_pkg::LEN_REG_W-1:0]);
    else held = mbf_pkg::CFG_DATA_W'(d[mbf_pkg::WEIGHT_W-1:0]);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= mbf_pkg::CFG_ADDR_W'({id, 2'b00});
    cfg_pwdata  <= d;
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    if (cfg_prdata !== held) flag_mismatch("register readback", cfg_prdata, held);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    if (id == mbf_pkg::REG_WINDOW_LEN) med_len_cfg = d[mbf_pkg::LEN_REG_W-1:0];
    else med_weight_cfg = d[mbf_pkg::WEIGHT_W-1:0];
    @(posedge clk);
  endtask

  task automatic push_sample(input logic [mbf_pkg::SAMPLE_W-1:0] s, input logic typed,
                             input res_beat_t want);
    res_beat_t due;
    smp_if.valid  <= 1'b1;
    smp_if.sample <= s;
    do @(posedge clk); while (!smp_if.ready);
    due = blend_median(s);
    pending_res.push_back(typed ? want : due);
    sent_cnt++;
    if (idle_on && $urandom_range(0, 3) == 0) begin
      smp_if.valid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
    end
  endtask

  task automatic drain_results();
    smp_if.valid <= 1'b0;
    while (pending_res.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  initial begin
    forever begin
      if (hold_req) begin
        res_if.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_req = 1'b0;
      end else if (idle_on && $urandom_range(0, 3) == 0) begin
        res_if.ready <= 1'b0;
        repeat ($urandom_range(1, 12)) @(posedge clk);
      end else begin
        res_if.ready <= 1'b1;
        repeat ($urandom_range(1, 12)) @(posedge clk);
      end
    end
  end

  always @(posedge clk) begin : res_check
    res_beat_t due;
    if (rst_n && res_if.valid && res_if.ready) begin
      if (pending_res.size() == 0) begin
        flag_mismatch("result with nothing expected", res_if.filtered, '0);
      end else begin
        due = pending_res.pop_front();
        if (res_if.filtered !== due.filtered)
          flag_mismatch("filtered", res_if.filtered, due.filtered);
        if (res_if.valid_res !== due.valid_res)
          flag_mismatch("valid_res", mbf_pkg::SAMPLE_W'(res_if.valid_res),
                        mbf_pkg::SAMPLE_W'(due.valid_res));
      end
    end
  end

  initial begin : stim
    int                             phase;
    int                             burst;
    int                             i;
    logic [mbf_pkg::SAMPLE_W-1:0]   base;
    logic [mbf_pkg::CFG_DATA_W-1:0] d;
    rst_n         <= 1'b0;
    cfg_psel      <= 1'b0;
    cfg_penable   <= 1'b0;
    cfg_pwrite    <= 1'b0;
    cfg_paddr     <= '0;
    cfg_pwdata    <= '0;
    smp_if.valid  <= 1'b0;
    smp_if.sample <= '0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    dir_tab = '{
      chk_row(POS_MAX, 32'd0, 1'b0),
      chk_row(NEG_MAX, 32'd0, 1'b0),
      chk_row(32'd0, 32'd0, 1'b0),
      chk_row(32'hFFFF_FFFF, 32'd0, 1'b0),
      smp_row(32'd1),
      smp_row(32'h7FFF_0000),
      cfg_row(mbf_pkg::REG_WINDOW_LEN, 32'hFFFF_FFE0),
      cfg_row(mbf_pkg::REG_BLEND_WEIGHT, 32'hFFFF_FFFF),
      chk_row(POS_MAX, POS_MAX, 1'b1),
      chk_row(NEG_MAX, NEG_MAX, 1'b1),
      cfg_row(mbf_pkg::REG_BLEND_WEIGHT, 32'd0),
      chk_row(32'd12345, 32'd12345, 1'b1),
      chk_row(32'hDEAD_BEEF, 32'hDEAD_BEEF, 1'b1),
      cfg_row(mbf_pkg::REG_WINDOW_LEN, 32'd31),
      cfg_row(mbf_pkg::REG_BLEND_WEIGHT, 32'd32768),
      chk_row(32'h0001_0000, 32'd0, 1'b0),
      chk_row(32'hFFFF_0000, 32'd0, 1'b0),
      chk_row(POS_MAX, 32'd0, 1'b0),
      chk_row(NEG_MAX, 32'd0, 1'b0),
      chk_row(32'h0000_8000, 32'd0, 1'b0),
      smp_row(32'h1234_5678),
      cfg_row(mbf_pkg::REG_BLEND_WEIGHT, 32'd65536),
      smp_row(32'hFFFF_FFFB),
      cfg_row(mbf_pkg::REG_WINDOW_LEN, 32'd2),
      smp_row(NEG_MAX),
      smp_row(POS_MAX),
      cfg_row(mbf_pkg::REG_WINDOW_LEN, 32'd3),
      cfg_row(mbf_pkg::REG_BLEND_WEIGHT, 32'd1),
      smp_row(32'd7),
      smp_row(32'hFFFF_FFF9),
      cfg_row(mbf_pkg::REG_WINDOW_LEN, 32'd16),
      smp_row(32'd3)
    };

    for (i = 0; i < DIR_N; i++) begin
      if (dir_tab[i].is_cfg) begin
        drain_results();
        cfg_write(dir_tab[i].reg_id, dir_tab[i].data);
      end else begin
        push_sample(dir_tab[i].data, dir_tab[i].typed, dir_tab[i].want);
      end
    end

    phase = 0;
    while (sent_cnt < ITEMS_TOTAL) begin
      drain_results();
      d = $urandom;
      case ($urandom_range(0, 5))
        0: d[mbf_pkg::LEN_REG_W-1:0] = 5'd1;
        1: d[mbf_pkg::LEN_REG_W-1:0] = 5'd16;
        2: d[mbf_pkg::LEN_REG_W-1:0] = 5'd0;
        3: d[mbf_pkg::LEN_REG_W-1:0] = mbf_pkg::LEN_REG_W'($urandom_range(17, 31));
        default: d[mbf_pkg::LEN_REG_W-1:0] = mbf_pkg::LEN_REG_W'($urandom_range(1, 16));
      endcase
      cfg_write(mbf_pkg::REG_WINDOW_LEN, d);
      d = $urandom;
      case ($urandom_range(0, 5))
        0: d[mbf_pkg::WEIGHT_W-1:0] = 17'd0;
        1: d[mbf_pkg::WEIGHT_W-1:0] = mbf_pkg::ONE_Q16;
        2: d[mbf_pkg::WEIGHT_W-1:0] = 17'd65535;
        3: d[mbf_pkg::WEIGHT_W-1:0] = mbf_pkg::WEIGHT_W'($urandom_range(65537, 131071));
        default: d[mbf_pkg::WEIGHT_W-1:0] = mbf_pkg::WEIGHT_W'($urandom_range(0, 65536));
      endcase
      cfg_write(mbf_pkg::REG_BLEND_WEIGHT, d);
      idle_on = (sent_cnt < ITEMS_TOTAL - 120);
      if (phase == 3) hold_req = 1'b1;
      base  = $urandom;
      burst = $urandom_range(20, 60);
      for (i = 0; i < burst; i++) push_sample(next_sample(base), 1'b0, '0);
      phase++;
    end

    drain_results();
    if (mismatch_cnt == 0 && pending_res.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

FILE: files.f
rtl/core/mbf_pkg.sv
rtl/core/mbf_if.sv
rtl/core/mbf_cfg.sv
rtl/core/mbf_window.sv
rtl/core/mbf_mac.sv
rtl/core/median_blend_filter_unit.sv
tb/sv/tb_median_blend_filter_unit.sv
